// ----- hw/rtl/mctr_pkg.sv -----
// Shared constants for the multi-channel relative timer unit.
// Field widths and the action and status codes. No dependencies.
package mctr_pkg;

   // Port field widths, fixed by the interface
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int FIELD_W  = 32;
   localparam int CSR_W    = 5;

   // Active timer count after reset
   localparam logic [CSR_W-1:0] CSR_ACTIVE_RESET = 5'd16;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DECLARE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DECLARED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SLOT_IDLE = 3'd5;

endpackage

// ----- hw/rtl/mctr_cell.sv -----
// One timer slot of the ring: flags, remaining count and period.
// Loads its neighbour's contents on every shift cycle. No package needed.
module mctr_cell #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  d_in_use,
   input  logic                  d_periodic,
   input  logic [TICK_WIDTH-1:0] d_remaining,
   input  logic [TICK_WIDTH-1:0] d_period,
   output logic                  q_in_use,
   output logic                  q_periodic,
   output logic [TICK_WIDTH-1:0] q_remaining,
   output logic [TICK_WIDTH-1:0] q_period
);

   logic                  in_use_ff;
   logic                  periodic_ff;
   logic [TICK_WIDTH-1:0] remaining_ff;
   logic [TICK_WIDTH-1:0] period_ff;

   // flags are cleared by reset, counts are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff   <= 1'b0;
         periodic_ff <= 1'b0;
      end else if (shift_en) begin
         in_use_ff   <= d_in_use;
         periodic_ff <= d_periodic;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         remaining_ff <= d_remaining;
         period_ff    <= d_period;
      end
   end

   assign q_in_use    = in_use_ff;
   assign q_periodic  = periodic_ff;
   assign q_remaining = remaining_ff;
   assign q_period    = period_ff;

endmodule

// ----- hw/rtl/multi_channel_relative_timer_unit.sv -----
// Top level of the multi-channel relative timer unit: ring of timer cells,
// the head update logic and the pass sequencer. Uses mctr_pkg and mctr_cell.
//
//   channel   ports                         handshake
//   request   start, busy, req_*            taken when start && !busy
//   response  rsp_valid, rsp_*              one-cycle strobe, cannot stall
//   config    csr_wr_en, csr_wr_data        written when csr_wr_en
//
// Every word makes one full turn of the cell ring, shifting each slot through
// the head in turn, then the S_DONE state that forms the final word.
// A new word is taken only once the turn is over and busy has dropped.
// Expiry words come out during the turn, each held back until the next expiry
// is found; the word flagged rsp_last ends the turn and carries the soonest timer.
// Synchronous reset clears the sequencer and all slot flags; no clearing pass.
module multi_channel_relative_timer_unit #(
   parameter int NUM_TIMERS = 16,
   parameter int TICK_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [mctr_pkg::ACTION_W-1:0] req_action,
   input  logic [mctr_pkg::FIELD_W-1:0]  req_elapsed_ticks,
   input  logic [mctr_pkg::FIELD_W-1:0]  req_duration,
   input  logic                          req_periodic,
   input  logic [mctr_pkg::SLOT_W-1:0]   req_timer_id,
   // response
   output logic                          rsp_valid,
   output logic [mctr_pkg::STATUS_W-1:0] rsp_status,
   output logic [mctr_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_next_valid,
   output logic [mctr_pkg::SLOT_W-1:0]   rsp_next_slot,
   output logic [mctr_pkg::FIELD_W-1:0]  rsp_next_remaining,
   output logic                          rsp_last,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [mctr_pkg::CSR_W-1:0]    csr_wr_data
);

   import mctr_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW    = IDX_W + CSR_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   // sequencer registers
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [TICK_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [TICK_WIDTH-1:0] duration_ff, duration_in;
   logic                  periodic_ff, periodic_in;
   logic [SLOT_W-1:0]     timer_id_ff, timer_id_in;
   logic                  claimed_ff, claimed_in;
   logic                  held_valid_ff, held_valid_in;
   logic [STATUS_W-1:0]   held_status_ff, held_status_in;
   logic [SLOT_W-1:0]     held_slot_ff, held_slot_in;
   logic                  min_found_ff, min_found_in;
   logic [SLOT_W-1:0]     min_slot_ff, min_slot_in;
   logic [TICK_WIDTH-1:0] min_rem_ff, min_rem_in;
   logic [CSR_W-1:0]      csr_active_ff, csr_active_in;
   // response registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_next_valid_ff, rsp_next_valid_in;
   logic [SLOT_W-1:0]     rsp_next_slot_ff, rsp_next_slot_in;
   logic [FIELD_W-1:0]    rsp_next_rem_ff, rsp_next_rem_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ring of cells
   logic                  q_in_use   [NUM_TIMERS];
   logic                  q_periodic [NUM_TIMERS];
   logic [TICK_WIDTH-1:0] q_remaining[NUM_TIMERS];
   logic [TICK_WIDTH-1:0] q_period   [NUM_TIMERS];

   // head update result, fed into the tail cell
   logic                  h_in_use;
   logic                  h_periodic;
   logic [TICK_WIDTH-1:0] h_remaining;
   logic [TICK_WIDTH-1:0] h_period;

   logic                  shift_en;

   // helper values
   logic [CW-1:0]                csr_ext;
   logic [CW-1:0]                active_n;
   logic [CW-1:0]                step_ext;
   logic [CW-1:0]                id_ext;
   logic                         live;
   logic [IDX_W+SLOT_W-1:0]      step_wide;
   logic [SLOT_W-1:0]            step_slot;
   logic [TICK_WIDTH+FIELD_W-1:0] elapsed_wide;
   logic [TICK_WIDTH+FIELD_W-1:0] duration_wide;
   logic [TICK_WIDTH+FIELD_W-1:0] min_rem_wide;
   logic                         expire;

   assign shift_en = (state_ff == S_RUN);

   genvar k;
   generate
      for (k = 0; k < NUM_TIMERS; k++) begin : g_cell
         if (k == NUM_TIMERS - 1) begin : g_tail
            mctr_cell #(.TICK_WIDTH(TICK_WIDTH)) u_cell (
               .clock       (clock),
               .reset       (reset),
               .shift_en    (shift_en),
               .d_in_use    (h_in_use),
               .d_periodic  (h_periodic),
               .d_remaining (h_remaining),
               .d_period    (h_period),
               .q_in_use    (q_in_use[k]),
               .q_periodic  (q_periodic[k]),
               .q_remaining (q_remaining[k]),
               .q_period    (q_period[k])
            );
         end else begin : g_body
            mctr_cell #(.TICK_WIDTH(TICK_WIDTH)) u_cell (
               .clock       (clock),
               .reset       (reset),
               .shift_en    (shift_en),
               .d_in_use    (q_in_use[k+1]),
               .d_periodic  (q_periodic[k+1]),
               .d_remaining (q_remaining[k+1]),
               .d_period    (q_period[k+1]),
               .q_in_use    (q_in_use[k]),
               .q_periodic  (q_periodic[k]),
               .q_remaining (q_remaining[k]),
               .q_period    (q_period[k])
            );
         end
      end
   endgenerate

   // active slot count, clamped to 1 .. NUM_TIMERS
   always_comb begin
      csr_ext = {{IDX_W{1'b0}}, csr_active_ff};
      if (csr_ext == '0)
         active_n = CW'(1);
      else if (csr_ext > CW'(NUM_TIMERS))
         active_n = CW'(NUM_TIMERS);
      else
         active_n = csr_ext;
   end

   assign step_ext      = {{CSR_W{1'b0}}, step_ff};
   assign id_ext        = {{(CW-SLOT_W){1'b0}}, timer_id_ff};
   assign live          = (step_ext < active_n);
   assign step_wide     = {{SLOT_W{1'b0}}, step_ff};
   assign step_slot     = step_wide[SLOT_W-1:0];
   assign elapsed_wide  = {{TICK_WIDTH{1'b0}}, req_elapsed_ticks};
   assign duration_wide = {{TICK_WIDTH{1'b0}}, req_duration};
   assign min_rem_wide  = {{FIELD_W{1'b0}}, min_rem_ff};

   // head: update the slot now at cell 0
   always_comb begin
      h_in_use    = q_in_use[0];
      h_periodic  = q_periodic[0];
      h_remaining = q_remaining[0];
      h_period    = q_period[0];
      expire      = 1'b0;
      if (live && q_in_use[0]) begin
         case (action_ff)
            ACT_ADVANCE: begin
               if (elapsed_ff < q_remaining[0]) begin
                  h_remaining = q_remaining[0] - elapsed_ff;
               end else begin
                  expire = 1'b1;
                  if (q_periodic[0] && (q_period[0] != '0))
                     h_remaining = q_period[0];
                  else
                     h_in_use = 1'b0;
               end
            end
            ACT_RELEASE: begin
               if (step_ext == id_ext)
                  h_in_use = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (live && (action_ff == ACT_DECLARE) && !claimed_ff) begin
         h_in_use    = 1'b1;
         h_periodic  = periodic_ff;
         h_remaining = duration_ff;
         h_period    = duration_ff;
      end
   end

   // sequencer next state
   always_comb begin
      state_in          = state_ff;
      step_in           = step_ff;
      action_in         = action_ff;
      elapsed_in        = elapsed_ff;
      duration_in       = duration_ff;
      periodic_in       = periodic_ff;
      timer_id_in       = timer_id_ff;
      claimed_in        = claimed_ff;
      held_valid_in     = held_valid_ff;
      held_status_in    = held_status_ff;
      held_slot_in      = held_slot_ff;
      min_found_in      = min_found_ff;
      min_slot_in       = min_slot_ff;
      min_rem_in        = min_rem_ff;
      csr_active_in     = csr_wr_en ? csr_wr_data : csr_active_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_next_valid_in = rsp_next_valid_ff;
      rsp_next_slot_in  = rsp_next_slot_ff;
      rsp_next_rem_in   = rsp_next_rem_ff;
      rsp_last_in       = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in     = S_RUN;
               step_in      = '0;
               action_in    = req_action;
               elapsed_in   = elapsed_wide[TICK_WIDTH-1:0];
               duration_in  = duration_wide[TICK_WIDTH-1:0];
               periodic_in  = req_periodic;
               timer_id_in  = req_timer_id;
               claimed_in   = 1'b0;
               min_found_in = 1'b0;
               min_slot_in  = '0;
               min_rem_in   = '0;
               // preset the word a command gives when nothing matches
               held_valid_in = (req_action != ACT_ADVANCE);
               case (req_action)
                  ACT_DECLARE: begin
                     held_status_in = ST_FULL;
                     held_slot_in   = '0;
                  end
                  ACT_RELEASE: begin
                     held_status_in = ST_SLOT_IDLE;
                     held_slot_in   = req_timer_id;
                  end
                  default: begin
                     held_status_in = ST_NONE;
                     held_slot_in   = '0;
                  end
               endcase
            end
         end
         S_RUN: begin
            // expiry: send the word held back, hold this one
            if (expire) begin
               if (held_valid_ff) begin
                  rsp_valid_in      = 1'b1;
                  rsp_status_in     = ST_EXPIRED;
                  rsp_slot_in       = held_slot_ff;
                  rsp_next_valid_in = 1'b0;
                  rsp_next_slot_in  = '0;
                  rsp_next_rem_in   = '0;
                  rsp_last_in       = 1'b0;
               end
               held_valid_in  = 1'b1;
               held_status_in = ST_EXPIRED;
               held_slot_in   = step_slot;
            end
            if (live && q_in_use[0] && (action_ff == ACT_RELEASE)
                && (step_ext == id_ext))
               held_status_in = ST_RELEASED;
            if (live && !q_in_use[0] && (action_ff == ACT_DECLARE) && !claimed_ff) begin
               claimed_in     = 1'b1;
               held_status_in = ST_DECLARED;
               held_slot_in   = step_slot;
            end
            // running minimum over updated slots, first slot wins a tie
            if (live && h_in_use && (!min_found_ff || (h_remaining < min_rem_ff))) begin
               min_found_in = 1'b1;
               min_slot_in  = step_slot;
               min_rem_in   = h_remaining;
            end
            if (step_ff == IDX_W'(NUM_TIMERS - 1))
               state_in = S_DONE;
            else
               step_in = step_ff + 1'b1;
         end
         S_DONE: begin
            state_in          = S_IDLE;
            rsp_valid_in      = 1'b1;
            rsp_status_in     = held_valid_ff ? held_status_ff : ST_NONE;
            rsp_slot_in       = held_valid_ff ? held_slot_ff : '0;
            rsp_next_valid_in = min_found_ff;
            rsp_next_slot_in  = min_slot_ff;
            rsp_next_rem_in   = min_rem_wide[FIELD_W-1:0];
            rsp_last_in       = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         claimed_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         min_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         csr_active_ff <= CSR_ACTIVE_RESET;
      end else begin
         state_ff      <= state_in;
         claimed_ff    <= claimed_in;
         held_valid_ff <= held_valid_in;
         min_found_ff  <= min_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         csr_active_ff <= csr_active_in;
      end
      step_ff           <= step_in;
      action_ff         <= action_in;
      elapsed_ff        <= elapsed_in;
      duration_ff       <= duration_in;
      periodic_ff       <= periodic_in;
      timer_id_ff       <= timer_id_in;
      held_status_ff    <= held_status_in;
      held_slot_ff      <= held_slot_in;
      min_slot_ff       <= min_slot_in;
      min_rem_ff        <= min_rem_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_next_valid_ff <= rsp_next_valid_in;
      rsp_next_slot_ff  <= rsp_next_slot_in;
      rsp_next_rem_ff   <= rsp_next_rem_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_next_valid     = rsp_next_valid_ff;
   assign rsp_next_slot      = rsp_next_slot_ff;
   assign rsp_next_remaining = rsp_next_rem_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTH
   // the final word of a turn appears as busy drops
   a_done_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last))
      else $error("turn ended without a final word");

   // words that are not last are expiries sent during a turn
   a_mid_expiry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy && rsp_status == ST_EXPIRED))
      else $error("stray non-final word");

   // a taken word starts a turn
   a_start_turn: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("word taken but no turn started");

   // a final word carries no soonest timer unless one was found
   a_next_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_next_valid) |->
         (rsp_next_slot == '0 && rsp_next_remaining == '0))
      else $error("soonest fields set with no timer in use");
`endif

endmodule
